[hw/rtl/dcc_pkg.sv]
// Shared types and constants for the delayed credit counter.
// No dependencies; imported by the top level and the testbench.
package dcc_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    localparam logic [1:0] CFG_CREDIT_LIMIT = 2'd0;
    localparam logic [1:0] CFG_ADD_DELAY    = 2'd1;
    localparam logic [1:0] CFG_REMOVE_DELAY = 2'd2;

    localparam int          SLOT_W             = 16;
    localparam logic [11:0] CREDIT_LIMIT_RESET = 12'd16;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        immediate;
        logic [7:0]  extra_delay;
        logic [11:0] amount;
    } in_item_t;

    typedef struct packed {
        logic [11:0] credit_count;
        logic        out_of_credit;
    } out_item_t;

endpackage

[hw/rtl/dcc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/delayed_credit_counter_top.sv]
// Delayed credit counter top level: count, timing-wheel RAM and result register.
// Depends on dcc_pkg and dcc_ram.
//
// Credit counter saturating between 0 and the programmed limit, with adds and
// removes that are applied at once or queued in a timing-wheel slot. One item
// is accepted per clock unless the output stalls; the result is registered
// behind the execute stage. Each tick or queued item does a read-modify-write
// of one wheel slot: the read is issued on acceptance and the write lands as
// the item leaves the execute stage, a one-entry forward register covering a
// read of the slot being written. After reset the wheel RAM is cleared one slot
// per cycle; no item is accepted meanwhile, but configuration writes are.
module delayed_credit_counter_top #(
    parameter int WHEEL_SLOTS = 256,
    parameter int COUNT_BITS  = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dcc_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output dcc_pkg::out_item_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [11:0]       cfg_wdata
);

    import dcc_pkg::*;

    localparam int SB = (WHEEL_SLOTS > 2) ? $clog2(WHEEL_SLOTS) : 1;
    localparam int LW = ((SB > 9) ? SB : 9) + 1;
    localparam int W  = ((COUNT_BITS > SLOT_W) ? COUNT_BITS : SLOT_W) + 2;

    localparam logic [LW-1:0] LAST_SLOT = LW'(WHEEL_SLOTS - 1);
    localparam logic [LW-1:0] NSLOTS    = LW'(WHEEL_SLOTS);
    localparam logic [W-1:0]  CAP_W     = (W'(1) << COUNT_BITS) - W'(1);
    localparam logic [W-1:0]  RST_W     = (W'(CREDIT_LIMIT_RESET) < CAP_W) ?
                                          W'(CREDIT_LIMIT_RESET) : CAP_W;

    localparam logic signed [16:0] SAT_HI = 17'sd32767;
    localparam logic signed [16:0] SAT_LO = -17'sd32768;

    // configuration
    logic [COUNT_BITS-1:0] lim_reg;
    logic [7:0]            add_delay_reg;
    logic [7:0]            remove_delay_reg;

    // architectural state
    logic [COUNT_BITS-1:0] credits_reg, credits_next;
    logic                  zero_reg, zero_next;
    logic [SB-1:0]         time_reg, time_next;

    // clearing pass
    logic          clr_reg;
    logic [SB-1:0] clr_idx_reg;

    // execute stage
    logic                  b_valid_reg;
    logic [1:0]            b_op_reg;
    logic                  b_imm_reg;
    logic [11:0]           b_amt_reg;
    logic [SB-1:0]         b_slot_reg;

    // last wheel write, forwarded to a read of the same slot
    logic                  fwd_valid_reg;
    logic [SB-1:0]         fwd_slot_reg;
    logic [SLOT_W-1:0]     fwd_data_reg;

    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    logic                  accept, b_adv;
    logic [SB-1:0]         a_slot;
    logic [LW-1:0]         lat, lat_c, slot_sum;
    logic [7:0]            base_delay;

    logic [SLOT_W-1:0]     rd_data, slot_val;
    logic                  wr_en;
    logic [SB-1:0]         wr_addr;
    logic [SLOT_W-1:0]     wr_data;
    logic                  b_wr;
    logic [SLOT_W-1:0]     b_wr_data;

    logic signed [W-1:0]   tick_sum;
    logic [W-1:0]          lim_w, cred_w, amt_w, add_sum;
    logic signed [16:0]    q_sum;
    logic [W-1:0]          new_lim_w;

    assign accept   = in_valid && in_ready;
    assign b_adv    = b_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clr_reg && (!b_valid_reg || b_adv);

    // slot address for the incoming item
    always_comb
    begin
        base_delay = (in_data.opcode == OP_REMOVE) ? remove_delay_reg : add_delay_reg;
        lat        = LW'(base_delay) + LW'(in_data.extra_delay);
        lat_c      = (lat > LAST_SLOT) ? LAST_SLOT : lat;
        slot_sum   = LW'(time_reg) + lat_c;
        if (slot_sum >= NSLOTS)
        begin
            slot_sum = slot_sum - NSLOTS;
        end
        if (in_data.opcode == OP_TICK)
        begin
            a_slot = time_reg;
        end
        else
        begin
            a_slot = slot_sum[SB-1:0];
        end
        if (in_data.opcode == OP_TICK)
        begin
            time_next = (LW'(time_reg) == LAST_SLOT) ? '0 : time_reg + SB'(1);
        end
        else
        begin
            time_next = time_reg;
        end
    end

    // execute: update of the count and, for ticks and queued changes, read-modify-write of the slot
    always_comb
    begin
        slot_val  = (fwd_valid_reg && fwd_slot_reg == b_slot_reg) ? fwd_data_reg : rd_data;
        lim_w     = W'(lim_reg);
        cred_w    = W'(credits_reg);
        amt_w     = W'(b_amt_reg);
        tick_sum  = $signed(cred_w) + $signed({{(W-SLOT_W){slot_val[SLOT_W-1]}}, slot_val});
        add_sum   = cred_w + amt_w;
        if (b_op_reg == OP_ADD)
        begin
            q_sum = $signed({slot_val[SLOT_W-1], slot_val}) + $signed({5'd0, b_amt_reg});
        end
        else
        begin
            q_sum = $signed({slot_val[SLOT_W-1], slot_val}) - $signed({5'd0, b_amt_reg});
        end
        credits_next = credits_reg;
        zero_next    = zero_reg;
        b_wr         = 1'b0;
        b_wr_data    = '0;
        case (b_op_reg) inside
            OP_TICK:
            begin
                if (tick_sum >= $signed(lim_w))
                begin
                    credits_next = lim_reg;
                end
                else if (tick_sum <= $signed(W'(0)))
                begin
                    credits_next = '0;
                end
                else
                begin
                    credits_next = tick_sum[COUNT_BITS-1:0];
                end
                zero_next = (credits_next == '0);
                b_wr      = 1'b1;
            end
            OP_ADD, OP_REMOVE:
            begin
                if (b_imm_reg)
                begin
                    if (b_op_reg == OP_ADD)
                    begin
                        credits_next = (add_sum >= lim_w) ? lim_reg : add_sum[COUNT_BITS-1:0];
                    end
                    else if (amt_w >= cred_w)
                    begin
                        credits_next = '0;
                    end
                    else
                    begin
                        credits_next = cred_w[COUNT_BITS-1:0] - amt_w[COUNT_BITS-1:0];
                    end
                end
                else
                begin
                    b_wr = 1'b1;
                    if (q_sum > SAT_HI)
                    begin
                        b_wr_data = 16'h7fff;
                    end
                    else if (q_sum < SAT_LO)
                    begin
                        b_wr_data = 16'h8000;
                    end
                    else
                    begin
                        b_wr_data = q_sum[SLOT_W-1:0];
                    end
                end
            end
            default:
            begin
                credits_next = credits_reg;
            end
        endcase
    end

    assign wr_en   = clr_reg || (b_adv && b_wr);
    assign wr_addr = clr_reg ? clr_idx_reg : b_slot_reg;
    assign wr_data = clr_reg ? '0 : b_wr_data;

    dcc_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(WHEEL_SLOTS)
    ) u_wheel (
        .clk  (clk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (accept),
        .raddr(a_slot),
        .rdata(rd_data)
    );

    assign new_lim_w = (W'(cfg_wdata) < CAP_W) ? W'(cfg_wdata) : CAP_W;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg          <= RST_W[COUNT_BITS-1:0];
            add_delay_reg    <= '0;
            remove_delay_reg <= '0;
            credits_reg      <= RST_W[COUNT_BITS-1:0];
            zero_reg         <= 1'b0;
            time_reg         <= '0;
            clr_reg          <= 1'b1;
            clr_idx_reg      <= '0;
            b_valid_reg      <= 1'b0;
            fwd_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (clr_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SB'(1);
                if (LW'(clr_idx_reg) == LAST_SLOT)
                begin
                    clr_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                time_reg <= time_next;
            end
            if (accept)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv)
            begin
                credits_reg   <= credits_next;
                zero_reg      <= zero_next;
                out_valid_reg <= 1'b1;
                if (b_wr)
                begin
                    fwd_valid_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CREDIT_LIMIT:
                    begin
                        lim_reg     <= new_lim_w[COUNT_BITS-1:0];
                        credits_reg <= new_lim_w[COUNT_BITS-1:0];
                    end
                    CFG_ADD_DELAY:    add_delay_reg    <= cfg_wdata[7:0];
                    CFG_REMOVE_DELAY: remove_delay_reg <= cfg_wdata[7:0];
                    default:          ;
                endcase
            end
        end
    end

    logic [W-1:0] cnt_out_w;
    assign cnt_out_w = W'(credits_next);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_op_reg   <= in_data.opcode;
            b_imm_reg  <= in_data.immediate;
            b_amt_reg  <= in_data.amount;
            b_slot_reg <= a_slot;
        end
        if (b_adv && b_wr)
        begin
            fwd_slot_reg <= b_slot_reg;
            fwd_data_reg <= b_wr_data;
        end
        if (b_adv)
        begin
            out_data_reg.credit_count  <= cnt_out_w[11:0];
            out_data_reg.out_of_credit <= zero_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // no item enters while the wheel is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !in_ready)
        else $error("item accepted during wheel clear");

    // count never exceeds the effective limit
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        credits_reg <= lim_reg)
        else $error("credit count above limit");

    // a tick leaves the zero flag consistent with the count
    a_tick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && b_op_reg == OP_TICK && !cfg_we) |=> (zero_reg == (credits_reg == '0)))
        else $error("zero flag inconsistent after tick");

    // an accepted item always occupies the execute stage next cycle
    a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> b_valid_reg)
        else $error("accepted item lost before execute");

endmodule

[test/tb_top.sv]
// Self-checking testbench for delayed_credit_counter_top: random and directed credit items
// against a cycle-free predictor of the count, zero flag and timing wheel.
// Depends on dcc_pkg and the delayed_credit_counter_top RTL.
module tb_top;
    import dcc_pkg::*;

    localparam int WHEEL_SLOTS = 256;
    localparam int COUNT_BITS  = 12;
    localparam int MAX_CYCLES  = 100000;

    // Predicts count and zero flag per item and checks results in order.
    class credit_tracker;
        logic [11:0]        limit_reg;
        logic [7:0]         add_lat;
        logic [7:0]         rem_lat;
        int                 credits;
        bit                 zero_flag;
        int                 now_slot;
        logic signed [15:0] wheel[WHEEL_SLOTS];
        out_item_t          expected_q[$];
        int                 errors;

        function new();
            limit_reg = CREDIT_LIMIT_RESET;
            add_lat   = '0;
            rem_lat   = '0;
            zero_flag = 1'b0;
            now_slot  = 0;
            errors    = 0;
            foreach (wheel[i]) wheel[i] = '0;
            credits = cap();
        endfunction

        function int cap();
            int c;
            c = (1 << COUNT_BITS) - 1;
            return (int'(limit_reg) < c) ? int'(limit_reg) : c;
        endfunction

        function void configure(logic [1:0] idx, logic [11:0] val);
            case (idx)
                CFG_CREDIT_LIMIT: begin
                    limit_reg = val;
                    credits   = cap();
                end
                CFG_ADD_DELAY:    add_lat = val[7:0];
                CFG_REMOVE_DELAY: rem_lat = val[7:0];
                default: ;
            endcase
        endfunction

        function void schedule_change(int base, int extra, int delta);
            int lat;
            int slot;
            int s;
            lat = base + extra;
            if (lat > WHEEL_SLOTS - 1) lat = WHEEL_SLOTS - 1;
            slot = (now_slot + lat) % WHEEL_SLOTS;
            s = int'(wheel[slot]) + delta;
            if (s > 32767) s = 32767;
            if (s < -32768) s = -32768;
            wheel[slot] = s[15:0];
        endfunction

        function void note_item(in_item_t it);
            int lim;
            int t;
            out_item_t res;
            lim = cap();
            case (opcode_t'(it.opcode))
                OP_TICK: begin
                    t = credits + int'(wheel[now_slot]);
                    if (t >= lim) credits = lim;
                    else if (t <= 0) credits = 0;
                    else credits = t;
                    zero_flag = (credits == 0);
                    wheel[now_slot] = '0;
                    now_slot = (now_slot + 1) % WHEEL_SLOTS;
                end
                OP_ADD: begin
                    if (it.immediate) begin
                        t = credits + int'(it.amount);
                        credits = (t >= lim) ? lim : t;
                    end else begin
                        schedule_change(int'(add_lat), int'(it.extra_delay), int'(it.amount));
                    end
                end
                OP_REMOVE: begin
                    if (it.immediate)
                        credits = (int'(it.amount) >= credits) ? 0 : credits - int'(it.amount);
                    else
                        schedule_change(int'(rem_lat), int'(it.extra_delay), -int'(it.amount));
                end
                default: ;
            endcase
            res.credit_count  = credits[11:0];
            res.out_of_credit = zero_flag;
            expected_q.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_item;
            if (expected_q.size() == 0) begin
                $display("%0t: result with no item pending: count %0d flag %0d",
                         $time, got.credit_count, got.out_of_credit);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            if (got.credit_count !== exp_item.credit_count) begin
                $display("%0t: credit_count expected %0d actual %0d",
                         $time, exp_item.credit_count, got.credit_count);
                errors++;
            end
            if (got.out_of_credit !== exp_item.out_of_credit) begin
                $display("%0t: out_of_credit expected %0d actual %0d",
                         $time, exp_item.out_of_credit, got.out_of_credit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_wdata;

    credit_tracker sb;
    bit quiet;
    int cycles;
    int sent;

    delayed_credit_counter_top #(
        .WHEEL_SLOTS(WHEEL_SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stall bursts, none once quiet.
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (quiet) begin
                out_ready = 1'b1;
            end else if (stall > 0) begin
                stall--;
                out_ready = 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6) - 1;
                out_ready = 1'b0;
            end else begin
                out_ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_item(in_data);
            if (out_valid && out_ready) sb.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("delayed_credit_counter_top: mismatch");
            $finish;
        end
    end

    function automatic in_item_t make_item(opcode_t op, bit imm, int extra, int amt);
        in_item_t it;
        it.opcode      = op;
        it.immediate   = imm;
        it.extra_delay = extra[7:0];
        it.amount      = amt[11:0];
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(in_item_t it);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
        end
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (opcode_t'(it.opcode) != OP_NONE) sent++;
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.configure(idx, val);
    endtask

    task automatic set_regs(int lim, int add_d, int rem_d);
        write_reg(CFG_CREDIT_LIMIT, lim[11:0]);
        write_reg(CFG_ADD_DELAY, add_d[11:0]);
        write_reg(CFG_REMOVE_DELAY, rem_d[11:0]);
    endtask

    task automatic run_random(int n);
        int stop;
        int r;
        int k;
        int extra;
        opcode_t op;
        stop = sent + n;
        while (sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                // a few changes, then ticks to bring them in
                k = $urandom_range(1, 4);
                repeat (k)
                begin
                    op = $urandom_range(0, 1) ? OP_ADD : OP_REMOVE;
                    send_item(make_item(op, $urandom_range(0, 3) == 0, $urandom_range(0, 4),
                              $urandom_range(0, 1) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 20)));
                end
                k = $urandom_range(1, 4);
                repeat (k) send_item(make_item(OP_TICK, 1'b0, 0, 0));
            end else if (r < 65) begin
                // pile large changes into one slot to push it into saturation
                op = $urandom_range(0, 1) ? OP_ADD : OP_REMOVE;
                extra = $urandom_range(0, 3);
                k = $urandom_range(9, 11);
                repeat (k) send_item(make_item(op, 1'b0, extra, $urandom_range(3500, 4095)));
                k = $urandom_range(1, 10);
                repeat (k) send_item(make_item(OP_TICK, 1'b0, 0, 0));
            end else begin
                send_item(make_item(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 1),
                          $urandom_range(0, 255), $urandom_range(0, 4095)));
            end
        end
    endtask

    initial
    begin
        int p;
        sb = new();
        quiet     = 1'b0;
        cycles    = 0;
        sent      = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed, reset settings: limit 16, no default latency.
        send_item(make_item(OP_ADD, 1'b1, 0, 4095));
        send_item(make_item(OP_REMOVE, 1'b1, 0, 4095));
        send_item(make_item(OP_TICK, 1'b0, 0, 0));
        // slot sum clips high, then low, queued into the current slot
        repeat (9) send_item(make_item(OP_ADD, 1'b0, 0, 4095));
        send_item(make_item(OP_TICK, 1'b0, 0, 0));
        repeat (9) send_item(make_item(OP_REMOVE, 1'b0, 0, 4095));
        send_item(make_item(OP_TICK, 1'b0, 0, 0));
        send_item(make_item(OP_NONE, 1'b1, 255, 4095));
        send_item(make_item(OP_ADD, 1'b0, 1, 7));
        send_item(make_item(OP_TICK, 1'b0, 0, 0));
        send_item(make_item(OP_TICK, 1'b0, 0, 0));
        drain();

        // extremes: latency clamps to the last wheel slot, WHEEL_SLOTS - 1
        set_regs(4095, 255, 255);
        run_random(100);
        drain();

        set_regs(0, 0, 0);
        run_random(50);
        drain();

        for (p = 0; p < 4; p++)
        begin
            set_regs($urandom_range(0, 3) == 0 ? $urandom_range(0, 4095) : $urandom_range(1, 40),
                     $urandom_range(0, 6), $urandom_range(0, 6));
            if (p == 3) quiet = 1'b1;
            run_random(50);
            if (p == 0) drain();
            run_random(50);
            drain();
        end

        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("delayed_credit_counter_top: match");
        else
            $display("delayed_credit_counter_top: mismatch");
        $finish;
    end
endmodule

[delayed_credit_counter_top.f]
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_ram.sv
hw/rtl/delayed_credit_counter_top.sv
test/tb_top.sv
